[rtl/core/spi_serial_sram_slave_unit_assert.svh]
// assertion macros for the spi serial sram slave
// expects clk and rst_n in the scope of each use
`ifndef SPI_SERIAL_SRAM_SLAVE_UNIT_ASSERT_SVH
`define SPI_SERIAL_SRAM_SLAVE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSS_ASSERT_NOW(lbl, ante, cons, msg)
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/sss_pkg.sv]
// shared types and constants for the spi serial sram slave
// no dependencies
package sss_pkg;

    localparam int ADDR_BITS_DEF = 17;
    localparam int ADDR_WIDE     = 24;

    localparam logic [7:0] CMD_WRITE  = 8'h02;
    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_RDMR   = 8'h05;
    localparam logic [7:0] CMD_WRMR   = 8'h01;
    localparam logic [7:0] MODE_RESET = 8'h41;

    typedef enum logic [5:0] {
        PH_CMD    = 6'b000001,
        PH_A2     = 6'b000010,
        PH_A1     = 6'b000100,
        PH_A0     = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_IGNORE = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        AC_NONE  = 3'd0,
        AC_WRITE = 3'd1,
        AC_READ  = 3'd2,
        AC_RDMR  = 3'd3,
        AC_WRMR  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_MEM  = 2'd1,
        RES_MODE = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic en;
        logic we;
    } ram_ctl_t;

endpackage

[rtl/core/sss_ram.sv]
// single-port byte memory with registered read data
// depends on sss_pkg for the control struct
module sss_ram #(
    parameter int ADDR_BITS = sss_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  sss_pkg::ram_ctl_t    ctl,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [7:0]           wdata,
    output logic [7:0]           rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/spi_serial_sram_slave_unit.sv]
// channel  dir  tdata         tuser
// s_*      in   mosi_byte     operation (1 = chip select released)
// m_*      out  miso_byte     -
//
// one item per clock: the command state, address and memory access settle at
// acceptance, the result sits in one output stage and is shown the next cycle.
// the single memory port is used at most once per item, read data is registered there.
// rst_n resets the command state and sets the mode register to MODE_RESET; the memory keeps its bytes.
// a waiting result holds s_tready low until m_tready takes it.
// top level of the spi serial sram slave, sequential mode
// depends on sss_pkg, sss_ram and the assertion header
`include "spi_serial_sram_slave_unit_assert.svh"

module spi_serial_sram_slave_unit #(
    parameter int ADDR_BITS = sss_pkg::ADDR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] mosi_byte
    input  logic       s_tuser,   // [0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] miso_byte
);

    localparam int AW = sss_pkg::ADDR_WIDE;

    sss_pkg::phase_t    phase_reg, phase_next;
    sss_pkg::cmd_t      cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [7:0]         mode_reg, mode_next;
    sss_pkg::res_sel_t  sel_next, p_sel_reg;
    logic               p_valid_reg;
    sss_pkg::ram_ctl_t  req, ram_ctl;
    logic [7:0]         ram_rdata;
    logic [AW-1:0]      addr_wide;
    logic [AW-1:0]      addr_hi, addr_mid, addr_lo;
    logic               acc;

    assign acc      = s_tvalid && s_tready;
    assign s_tready = !p_valid_reg || m_tready;

    assign addr_wide = AW'(addr_reg);
    assign addr_hi   = {s_tdata, 16'h0000};
    assign addr_mid  = addr_wide | {8'h00, s_tdata, 8'h00};
    assign addr_lo   = addr_wide | {16'h0000, s_tdata};

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        mode_next  = mode_reg;
        sel_next   = sss_pkg::RES_ZERO;
        req        = '0;
        if (s_tuser)
        begin
            phase_next = sss_pkg::PH_CMD;
            cmd_next   = sss_pkg::AC_NONE;
        end
        else
        begin
            unique case (phase_reg)
                sss_pkg::PH_CMD:
                begin
                    unique case (s_tdata)
                        sss_pkg::CMD_WRITE:
                        begin
                            cmd_next   = sss_pkg::AC_WRITE;
                            phase_next = sss_pkg::PH_A2;
                        end
                        sss_pkg::CMD_READ:
                        begin
                            cmd_next   = sss_pkg::AC_READ;
                            phase_next = sss_pkg::PH_A2;
                        end
                        sss_pkg::CMD_RDMR:
                        begin
                            cmd_next   = sss_pkg::AC_RDMR;
                            phase_next = sss_pkg::PH_DATA;
                        end
                        sss_pkg::CMD_WRMR:
                        begin
                            cmd_next   = sss_pkg::AC_WRMR;
                            phase_next = sss_pkg::PH_DATA;
                        end
                        default:
                        begin
                            cmd_next   = sss_pkg::AC_NONE;
                            phase_next = sss_pkg::PH_IGNORE;
                        end
                    endcase
                end
                sss_pkg::PH_A2:
                begin
                    addr_next  = addr_hi[ADDR_BITS-1:0];
                    phase_next = sss_pkg::PH_A1;
                end
                sss_pkg::PH_A1:
                begin
                    addr_next  = addr_mid[ADDR_BITS-1:0];
                    phase_next = sss_pkg::PH_A0;
                end
                sss_pkg::PH_A0:
                begin
                    addr_next  = addr_lo[ADDR_BITS-1:0];
                    phase_next = sss_pkg::PH_DATA;
                end
                sss_pkg::PH_DATA:
                begin
                    unique case (cmd_reg)
                        sss_pkg::AC_WRITE:
                        begin
                            req       = '{en: 1'b1, we: 1'b1};
                            addr_next = addr_reg + {{(ADDR_BITS-1){1'b0}}, 1'b1};
                        end
                        sss_pkg::AC_READ:
                        begin
                            req       = '{en: 1'b1, we: 1'b0};
                            sel_next  = sss_pkg::RES_MEM;
                            addr_next = addr_reg + {{(ADDR_BITS-1){1'b0}}, 1'b1};
                        end
                        sss_pkg::AC_RDMR:
                        begin
                            sel_next = sss_pkg::RES_MODE;
                        end
                        sss_pkg::AC_WRMR:
                        begin
                            mode_next  = s_tdata;
                            phase_next = sss_pkg::PH_IGNORE;
                        end
                        default:
                        begin
                            phase_next = sss_pkg::PH_IGNORE;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = sss_pkg::PH_IGNORE;
                end
            endcase
        end
    end

    assign ram_ctl = '{en: acc && req.en, we: req.we};

    sss_ram #(
        .ADDR_BITS(ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (addr_reg),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sss_pkg::PH_CMD;
            cmd_reg     <= sss_pkg::AC_NONE;
            addr_reg    <= '0;
            mode_reg    <= sss_pkg::MODE_RESET;
            p_valid_reg <= 1'b0;
            p_sel_reg   <= sss_pkg::RES_ZERO;
        end
        else
        begin
            if (s_tready)
            begin
                p_valid_reg <= s_tvalid;
            end
            if (acc)
            begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                addr_reg  <= addr_next;
                mode_reg  <= mode_next;
                p_sel_reg <= sel_next;
            end
        end
    end

    // mode register can only change by taking a new item, which replaces the result
    always_comb
    begin
        case (p_sel_reg)
            sss_pkg::RES_MEM:  m_tdata = ram_rdata;
            sss_pkg::RES_MODE: m_tdata = mode_reg;
            default:           m_tdata = 8'h00;
        endcase
    end

    assign m_tvalid = p_valid_reg;

    `SSS_ASSERT_NOW(a_ram_on_accept, ram_ctl.en, acc,
        "memory access without an accepted item")
    `SSS_ASSERT_NEXT(a_read_data_held,
        m_tvalid && !m_tready && p_sel_reg == sss_pkg::RES_MEM, $stable(ram_rdata),
        "read data moved under stall")
    `SSS_ASSERT_NEXT(a_release_idle, acc && s_tuser,
        phase_reg == sss_pkg::PH_CMD && cmd_reg == sss_pkg::AC_NONE,
        "release did not return to command phase")
    `SSS_ASSERT_NEXT(a_write_answers_zero, ram_ctl.en && ram_ctl.we,
        p_sel_reg == sss_pkg::RES_ZERO, "write data byte answered non-zero")

endmodule

[test/spi_serial_sram_slave_unit_test.sv]
`timescale 1ns / 100ps
// self-checking bench for the spi serial sram slave: byte stream in, answer bytes out
// depends on sss_pkg and spi_serial_sram_slave_unit

localparam int SRAM_ABITS = sss_pkg::ADDR_BITS_DEF;

// follows the command state and memory contents, queues the byte due for each item
class miso_tracker;
    sss_pkg::phase_t       ph;
    sss_pkg::cmd_t         cmd;
    logic [SRAM_ABITS-1:0] addr;
    logic [7:0]            mode_reg;
    logic [7:0]            mem [int unsigned];
    logic [7:0]            miso_due [$];
    int                    errors;
    int                    checked;

    function new();
        ph       = sss_pkg::PH_CMD;
        cmd      = sss_pkg::AC_NONE;
        addr     = '0;
        mode_reg = sss_pkg::MODE_RESET;
        errors   = 0;
        checked  = 0;
    endfunction

    // true when this item would fetch a byte that was never stored
    function bit hits_unwritten(bit op);
        return !op && ph == sss_pkg::PH_DATA && cmd == sss_pkg::AC_READ &&
               !mem.exists(addr);
    endfunction

    function logic [7:0] advance(bit op, logic [7:0] b);
        logic [7:0]  r;
        logic [31:0] wide;
        r = 8'h00;
        if (op)
        begin
            ph  = sss_pkg::PH_CMD;
            cmd = sss_pkg::AC_NONE;
        end
        else
        begin
            case (ph)
                sss_pkg::PH_CMD:
                begin
                    case (b)
                        sss_pkg::CMD_WRITE:
                        begin
                            cmd = sss_pkg::AC_WRITE;
                            ph  = sss_pkg::PH_A2;
                        end
                        sss_pkg::CMD_READ:
                        begin
                            cmd = sss_pkg::AC_READ;
                            ph  = sss_pkg::PH_A2;
                        end
                        sss_pkg::CMD_RDMR:
                        begin
                            cmd = sss_pkg::AC_RDMR;
                            ph  = sss_pkg::PH_DATA;
                        end
                        sss_pkg::CMD_WRMR:
                        begin
                            cmd = sss_pkg::AC_WRMR;
                            ph  = sss_pkg::PH_DATA;
                        end
                        default:
                        begin
                            cmd = sss_pkg::AC_NONE;
                            ph  = sss_pkg::PH_IGNORE;
                        end
                    endcase
                end
                sss_pkg::PH_A2:
                begin
                    wide = {24'h0, b} << 16;
                    addr = wide[SRAM_ABITS-1:0];
                    ph   = sss_pkg::PH_A1;
                end
                sss_pkg::PH_A1:
                begin
                    wide = 32'(addr) | ({24'h0, b} << 8);
                    addr = wide[SRAM_ABITS-1:0];
                    ph   = sss_pkg::PH_A0;
                end
                sss_pkg::PH_A0:
                begin
                    wide = 32'(addr) | {24'h0, b};
                    addr = wide[SRAM_ABITS-1:0];
                    ph   = sss_pkg::PH_DATA;
                end
                sss_pkg::PH_DATA:
                begin
                    case (cmd)
                        sss_pkg::AC_WRITE:
                        begin
                            mem[addr] = b;
                            addr      = addr + 1'b1;
                        end
                        sss_pkg::AC_READ:
                        begin
                            r    = mem.exists(addr) ? mem[addr] : 8'h00;
                            addr = addr + 1'b1;
                        end
                        sss_pkg::AC_RDMR:
                            r = mode_reg;
                        sss_pkg::AC_WRMR:
                        begin
                            mode_reg = b;
                            ph       = sss_pkg::PH_IGNORE;
                        end
                        default:
                            ph = sss_pkg::PH_IGNORE;
                    endcase
                end
                default:
                    ph = sss_pkg::PH_IGNORE;
            endcase
        end
        return r;
    endfunction

    function void note_mosi(bit op, logic [7:0] b);
        miso_due.push_back(advance(op, b));
    endfunction

    function void check_miso(logic [7:0] got);
        logic [7:0] want;
        checked++;
        if (miso_due.size() == 0)
        begin
            errors++;
            $error("miso_byte: expected nothing, got %02h", got);
        end
        else
        begin
            want = miso_due.pop_front();
            if (got !== want)
            begin
                errors++;
                $error("miso_byte: expected %02h, got %02h", want, got);
            end
        end
    endfunction
endclass

module spi_serial_sram_slave_unit_test;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int ITEM_GOAL      = 950;
    localparam logic [SRAM_ABITS-1:0] TOP_ADDR = '1;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] mosi_byte
    logic       s_tuser;   // [0] operation
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] miso_byte

    miso_tracker tracker = new();
    miso_tracker plan    = new();

    int sent;
    int planned;
    int idle_cycles;
    bit tx_lazy;
    bit rx_lazy;

    // stored runs, so reads only touch written bytes
    logic [SRAM_ABITS-1:0] run_start [$];
    int                    run_len   [$];

    spi_serial_sram_slave_unit #(
        .ADDR_BITS(SRAM_ABITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_item(bit op, logic [7:0] b);
        int gap;
        gap = tx_lazy ? $urandom_range(0, 12) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        tracker.note_mosi(op, b);
        sent++;
    endtask

    // a stray read of unwritten memory is turned into a release
    task automatic put(bit op, logic [7:0] b);
        bit o;
        o = op;
        if (plan.hits_unwritten(o))
            o = 1'b1;
        void'(plan.advance(o, b));
        planned++;
        send_item(o, b);
    endtask

    task automatic release_cs();
        put(1'b1, 8'($urandom));
    endtask

    task automatic hold_off();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.miso_due.size() != 0)
            @(posedge clk);
    endtask

    // three address bytes, msb first, random junk above the memory size
    task automatic send_addr(logic [SRAM_ABITS-1:0] a);
        logic [23:0] full;
        full = 24'(a) | 24'($urandom << SRAM_ABITS);
        put(1'b0, full[23:16]);
        put(1'b0, full[15:8]);
        put(1'b0, full[7:0]);
    endtask

    task automatic write_run(logic [SRAM_ABITS-1:0] a, int n, logic [7:0] first_byte,
                             bit fixed_first);
        put(1'b0, sss_pkg::CMD_WRITE);
        send_addr(a);
        for (int i = 0; i < n; i++)
            put(1'b0, (i == 0 && fixed_first) ? first_byte : 8'($urandom));
        run_start.push_back(a);
        run_len.push_back(n);
        release_cs();
    endtask

    task automatic read_run(logic [SRAM_ABITS-1:0] a, int n);
        put(1'b0, sss_pkg::CMD_READ);
        send_addr(a);
        repeat (n)
            put(1'b0, 8'($urandom));
        release_cs();
    endtask

    task automatic mode_read(int n);
        put(1'b0, sss_pkg::CMD_RDMR);
        repeat (n)
            put(1'b0, 8'($urandom));
        release_cs();
    endtask

    task automatic mode_write(logic [7:0] v, int extra);
        put(1'b0, sss_pkg::CMD_WRMR);
        put(1'b0, v);
        repeat (extra)
            put(1'b0, 8'($urandom));
        release_cs();
    endtask

    // receiver with random back-pressure
    initial
    begin
        int stall;
        rx_lazy = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rx_lazy = !rx_lazy;
            stall = rx_lazy ? $urandom_range(0, 12) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            tracker.check_miso(m_tdata);
        end
    end

    // ends the run if nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int                    kind;
        int                    idx;
        int                    off;
        logic [SRAM_ABITS-1:0] a;
        bit                    pressed;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        sent     = 0;
        planned  = 0;
        pressed  = 1'b0;
        tx_lazy  = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset mode value, wrap at the top, high address bits,
        // mode register write, unknown command, aborted and idle releases
        mode_read(1);
        release_cs();
        write_run(TOP_ADDR, 2, 8'hff, 1'b1);
        put(1'b0, sss_pkg::CMD_WRITE);
        put(1'b0, 8'hff);
        release_cs();
        read_run(TOP_ADDR, 2);
        mode_write(8'h00, 1);
        mode_read(1);
        put(1'b0, 8'hff);
        put(1'b0, 8'h00);
        release_cs();
        hold_off();

        // random: mostly well-formed transfers, some broken ones and noise
        while (planned < ITEM_GOAL)
        begin
            if ($urandom_range(0, 3) == 0)
                tx_lazy = !tx_lazy;
            if (!pressed && planned > ITEM_GOAL / 2)
            begin
                hold_off();
                pressed = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                if ($urandom_range(0, 3) == 0)
                    a = TOP_ADDR - SRAM_ABITS'($urandom_range(0, 7));
                else
                    a = SRAM_ABITS'($urandom);
                write_run(a, $urandom_range(1, 8), 8'h00, 1'b0);
            end
            else if (kind < 70)
            begin
                if (run_start.size() != 0)
                begin
                    idx = $urandom_range(0, run_start.size() - 1);
                    off = $urandom_range(0, run_len[idx] - 1);
                    a   = run_start[idx] + SRAM_ABITS'(off);
                    read_run(a, $urandom_range(1, run_len[idx] - off));
                end
            end
            else if (kind < 78)
                mode_read($urandom_range(1, 4));
            else if (kind < 85)
                mode_write(8'($urandom), $urandom_range(0, 2));
            else if (kind < 92)
            begin
                put(1'b0, $urandom_range(0, 1) ? sss_pkg::CMD_WRITE : sss_pkg::CMD_READ);
                repeat ($urandom_range(0, 2))
                    put(1'b0, 8'($urandom));
                release_cs();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    put($urandom_range(0, 5) == 0, 8'($urandom));
                release_cs();
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.miso_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("summary: %0d bytes sent, %0d answers checked over writes, reads,",
                 sent, tracker.checked);
        $display("summary: mode register access, wrap, unknown commands and aborts");
        if (tracker.errors == 0 && tracker.miso_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
